### design/kernel_swap_crossfade_controller_core_macros.svh
// Assertion helpers for the swap controller.
`ifndef KERNEL_SWAP_CROSSFADE_CONTROLLER_CORE_MACROS_SVH
`define KERNEL_SWAP_CROSSFADE_CONTROLLER_CORE_MACROS_SVH

// Check a property every clock, quiet while reset is high.
`define KSCC_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition leads to a consequence on the next clock.
`define KSCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/kscc_pkg.sv
package kscc_pkg;

   // Fixed field widths
   localparam int SAMPLE_BITS = 24;
   localparam int SIZE_BITS   = 24;
   localparam int PHASE_BITS  = 25;
   localparam int LEN_BITS    = 16;
   localparam int BLOCK_BITS  = 10;
   localparam int GAIN_BITS   = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [PHASE_BITS-1:0] QUARTER_TURN = 25'h100_0000;
   localparam logic [GAIN_BITS-1:0]  UNITY_GAIN   = 16'h8000;

   // Register reset values
   localparam logic [LEN_BITS-1:0]   FADE_LEN_RESET   = 16'd2048;
   localparam logic [PHASE_BITS-1:0] PHASE_STEP_RESET = 25'd8192;
   localparam logic [BLOCK_BITS-1:0] WARMUP_LIM_RESET = 10'd24;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CROSSFADE_LENGTH   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP         = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WARMUP_BLOCK_LIMIT = 2'd2;

   // Polynomial coefficients for the quarter sine
   localparam longint unsigned SIN_C1 = 64'd1686629713;
   localparam longint unsigned SIN_C3 = 64'd693598668;
   localparam longint unsigned SIN_C5 = 64'd85569306;
   localparam longint unsigned SIN_C7 = 64'd5026996;
   localparam longint unsigned SIN_C9 = 64'd172262;

   typedef enum logic [1:0] {
      KIND_SAMPLE       = 2'd0,
      KIND_POST_KNOWN   = 2'd1,
      KIND_POST_UNKNOWN = 2'd2,
      KIND_ABANDON      = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_STEADY = 2'd0,
      MODE_WARMUP = 2'd1,
      MODE_FADE   = 2'd2
   } mode_type;

   typedef struct packed {
      kind_type                       kind;
      logic [SIZE_BITS-1:0]           expected_size;
      logic [SIZE_BITS-1:0]           size_before_load;
      logic signed [SAMPLE_BITS-1:0]  engine_a_left;
      logic signed [SAMPLE_BITS-1:0]  engine_a_right;
      logic signed [SAMPLE_BITS-1:0]  engine_b_left;
      logic signed [SAMPLE_BITS-1:0]  engine_b_right;
      logic                           end_of_block;
      logic [SIZE_BITS-1:0]           idle_reported_size;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0]  out_left;
      logic signed [SAMPLE_BITS-1:0]  out_right;
      logic                           live_engine;
      logic [1:0]                     mode;
      logic                           post_accepted;
   } rsp_type;

   typedef struct packed {
      logic [LEN_BITS-1:0]   crossfade_length;
      logic [PHASE_BITS-1:0] phase_step;
      logic [BLOCK_BITS-1:0] warmup_block_limit;
   } cfg_type;

   // Mixer control for the word in flight (state before the word)
   typedef struct packed {
      logic sample_word;
      logic blend_en;
      logic live_select;
   } mix_ctrl_type;

   // Swap status after the word
   typedef struct packed {
      logic       live_engine;
      mode_type   mode;
      logic       post_accepted;
   } swap_status_type;

   // Equal-power gain for a table index, Q1.15 with 32768 as unity
   function automatic logic [GAIN_BITS-1:0] quarter_sine(input int unsigned idx,
                                                         input int unsigned table_bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      x  = longint'(idx) << (16 - table_bits);
      x2 = (x * x) >> 16;
      t  = SIN_C9;
      t  = SIN_C7 - ((t * x2) >> 16);
      t  = SIN_C5 - ((t * x2) >> 16);
      t  = SIN_C3 - ((t * x2) >> 16);
      t  = SIN_C1 - ((t * x2) >> 16);
      s  = (t * x) >> 16;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'(UNITY_GAIN)) begin
         s = 64'(UNITY_GAIN);
      end
      return s[GAIN_BITS-1:0];
   endfunction

endpackage

### design/kscc_gain_rom.sv
module kscc_gain_rom #(
   parameter int TABLE_BITS = 10
) (
   input  logic                            clock,
   input  logic [kscc_pkg::PHASE_BITS-1:0] phase,
   output logic [kscc_pkg::GAIN_BITS-1:0]  gain_new,
   output logic [kscc_pkg::GAIN_BITS-1:0]  gain_old
);
   import kscc_pkg::*;

   localparam int DEPTH = (1 << TABLE_BITS) + 1;
   localparam logic [TABLE_BITS:0] FULL_INDEX = {1'b1, {TABLE_BITS{1'b0}}};

   typedef logic [GAIN_BITS-1:0] rom_type [DEPTH];

   function automatic rom_type build_rom();
      rom_type r;
      for (int i = 0; i < DEPTH; i++) begin
         r[i] = quarter_sine(i, TABLE_BITS);
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [TABLE_BITS:0]    idx_new;
   logic [TABLE_BITS:0]    idx_old;
   logic [GAIN_BITS-1:0]   gain_new_ff;
   logic [GAIN_BITS-1:0]   gain_old_ff;

   // Phase never exceeds a quarter turn, so the index stays within the table
   assign idx_new = phase[PHASE_BITS-1 -: TABLE_BITS+1];
   assign idx_old = FULL_INDEX - idx_new;

   // Read both gains for the phase the next word will see
   always_ff @(posedge clock) begin
      gain_new_ff <= SINE_ROM[idx_new];
      gain_old_ff <= SINE_ROM[idx_old];
   end

   assign gain_new = gain_new_ff;
   assign gain_old = gain_old_ff;

endmodule

### design/kscc_blend.sv
module kscc_blend (
   input  kscc_pkg::mix_ctrl_type                 ctrl,
   input  logic signed [kscc_pkg::SAMPLE_BITS-1:0] engine_a,
   input  logic signed [kscc_pkg::SAMPLE_BITS-1:0] engine_b,
   input  logic [kscc_pkg::GAIN_BITS-1:0]          gain_new,
   input  logic [kscc_pkg::GAIN_BITS-1:0]          gain_old,
   output logic signed [kscc_pkg::SAMPLE_BITS-1:0] mixed
);
   import kscc_pkg::*;

   localparam int ACC_BITS = SAMPLE_BITS + GAIN_BITS + 2;
   localparam logic signed [ACC_BITS-1:0] OUT_MAX =
      ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_BITS-1:0] OUT_MIN = -OUT_MAX - ACC_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(16384);

   logic signed [SAMPLE_BITS-1:0] live_s;
   logic signed [SAMPLE_BITS-1:0] idle_s;
   logic signed [GAIN_BITS:0]     g_old_s;
   logic signed [GAIN_BITS:0]     g_new_s;
   logic signed [ACC_BITS-1:0]    acc;
   logic signed [ACC_BITS-1:0]    scaled;
   logic signed [SAMPLE_BITS-1:0] faded;

   // Pick live and idle engine
   assign live_s  = ctrl.live_select ? engine_b : engine_a;
   assign idle_s  = ctrl.live_select ? engine_a : engine_b;
   assign g_old_s = $signed({1'b0, gain_old});
   assign g_new_s = $signed({1'b0, gain_new});

   // Weighted sum, round, floor shift, saturate
   always_comb begin
      acc = ACC_BITS'(live_s * g_old_s) + ACC_BITS'(idle_s * g_new_s) + ROUND_HALF;
      scaled = acc >>> 15;
      if (scaled > OUT_MAX) begin
         faded = OUT_MAX[SAMPLE_BITS-1:0];
      end else if (scaled < OUT_MIN) begin
         faded = OUT_MIN[SAMPLE_BITS-1:0];
      end else begin
         faded = scaled[SAMPLE_BITS-1:0];
      end
   end

   // Control words carry silence
   always_comb begin
      if (!ctrl.sample_word) begin
         mixed = '0;
      end else if (ctrl.blend_en) begin
         mixed = faded;
      end else begin
         mixed = live_s;
      end
   end

endmodule

### design/kscc_swap_ctrl.sv
`include "kernel_swap_crossfade_controller_core_macros.svh"

module kscc_swap_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step_en,
   input  kscc_pkg::req_type                word,
   input  kscc_pkg::cfg_type                cfg,
   output kscc_pkg::mix_ctrl_type           mix_ctrl,
   output kscc_pkg::swap_status_type        status,
   output logic [kscc_pkg::PHASE_BITS-1:0]  phase_next
);
   import kscc_pkg::*;

   localparam logic [LEN_BITS-1:0]   SAMPLES_MAX = '1;
   localparam logic [BLOCK_BITS-1:0] BLOCKS_MAX  = '1;

   mode_type               swap_mode_ff,     swap_mode_in;
   logic                   live_select_ff,   live_select_in;
   logic [BLOCK_BITS-1:0]  warmup_blocks_ff, warmup_blocks_in;
   logic [LEN_BITS-1:0]    fade_samples_ff,  fade_samples_in;
   logic [PHASE_BITS-1:0]  fade_phase_ff,    fade_phase_in;
   logic [SIZE_BITS-1:0]   target_size_ff,   target_size_in;
   logic                   target_known_ff,  target_known_in;
   logic [SIZE_BITS-1:0]   prior_size_ff,    prior_size_in;
   logic                   post_accepted;

   logic [PHASE_BITS:0]    phase_sum;
   logic [LEN_BITS-1:0]    samples_inc;
   logic [BLOCK_BITS-1:0]  blocks_inc;
   logic                   size_matched;

   // Hold swap state
   always_ff @(posedge clock) begin
      if (reset) begin
         swap_mode_ff     <= MODE_STEADY;
         live_select_ff   <= 1'b0;
         warmup_blocks_ff <= '0;
         fade_samples_ff  <= '0;
         fade_phase_ff    <= '0;
         target_size_ff   <= '0;
         target_known_ff  <= 1'b0;
         prior_size_ff    <= '0;
      end else begin
         swap_mode_ff     <= swap_mode_in;
         live_select_ff   <= live_select_in;
         warmup_blocks_ff <= warmup_blocks_in;
         fade_samples_ff  <= fade_samples_in;
         fade_phase_ff    <= fade_phase_in;
         target_size_ff   <= target_size_in;
         target_known_ff  <= target_known_in;
         prior_size_ff    <= prior_size_in;
      end
   end

   // Saturating advances and the size check
   always_comb begin
      phase_sum   = {1'b0, fade_phase_ff} + {1'b0, cfg.phase_step};
      samples_inc = (fade_samples_ff != SAMPLES_MAX) ? fade_samples_ff + LEN_BITS'(1)
                                                     : fade_samples_ff;
      blocks_inc  = (warmup_blocks_ff != BLOCKS_MAX) ? warmup_blocks_ff + BLOCK_BITS'(1)
                                                     : warmup_blocks_ff;
      if (target_known_ff) begin
         size_matched = (word.idle_reported_size == target_size_ff);
      end else begin
         size_matched = (word.idle_reported_size != '0) &&
                        (word.idle_reported_size != prior_size_ff);
      end
   end

   // Next state for the word leaving the input register
   always_comb begin
      swap_mode_in     = swap_mode_ff;
      live_select_in   = live_select_ff;
      warmup_blocks_in = warmup_blocks_ff;
      fade_samples_in  = fade_samples_ff;
      fade_phase_in    = fade_phase_ff;
      target_size_in   = target_size_ff;
      target_known_in  = target_known_ff;
      prior_size_in    = prior_size_ff;
      post_accepted    = 1'b0;
      if (step_en) begin
         case (word.kind)
            KIND_POST_KNOWN, KIND_POST_UNKNOWN: begin
               if (swap_mode_ff == MODE_STEADY) begin
                  target_size_in   = (word.kind == KIND_POST_KNOWN) ? word.expected_size
                                                                    : '0;
                  target_known_in  = (word.kind == KIND_POST_KNOWN) &&
                                     (word.expected_size != '0);
                  prior_size_in    = word.size_before_load;
                  swap_mode_in     = MODE_WARMUP;
                  warmup_blocks_in = '0;
                  fade_samples_in  = '0;
                  fade_phase_in    = '0;
                  post_accepted    = 1'b1;
               end
            end
            KIND_ABANDON: begin
               swap_mode_in     = MODE_STEADY;
               warmup_blocks_in = '0;
               fade_samples_in  = '0;
               fade_phase_in    = '0;
               target_known_in  = 1'b0;
            end
            default: begin
               if (swap_mode_ff == MODE_FADE) begin
                  fade_phase_in   = (phase_sum > {1'b0, QUARTER_TURN}) ? QUARTER_TURN
                                                                      : phase_sum[PHASE_BITS-1:0];
                  fade_samples_in = samples_inc;
                  // Flip at the first block end past the fade length
                  if (word.end_of_block && (samples_inc >= cfg.crossfade_length)) begin
                     live_select_in   = ~live_select_ff;
                     swap_mode_in     = MODE_STEADY;
                     warmup_blocks_in = '0;
                     fade_samples_in  = '0;
                     fade_phase_in    = '0;
                     target_known_in  = 1'b0;
                  end
               end else if ((swap_mode_ff == MODE_WARMUP) && word.end_of_block) begin
                  warmup_blocks_in = blocks_inc;
                  if (size_matched || (blocks_inc >= cfg.warmup_block_limit)) begin
                     swap_mode_in    = MODE_FADE;
                     fade_samples_in = '0;
                     fade_phase_in   = '0;
                  end
               end
            end
         endcase
      end
   end

   // Mixer sees the state before the word; the result reports the state after it
   assign mix_ctrl.sample_word   = (word.kind == KIND_SAMPLE);
   assign mix_ctrl.blend_en      = (swap_mode_ff == MODE_FADE);
   assign mix_ctrl.live_select   = live_select_ff;
   assign status.live_engine     = live_select_in;
   assign status.mode            = swap_mode_in;
   assign status.post_accepted   = post_accepted;

   // Gain lookup is addressed with the phase being loaded into the phase register
   assign phase_next = reset ? '0 : fade_phase_in;

   `KSCC_ASSERT_ALWAYS(a_fade_state_idle, clock, reset, (swap_mode_ff != MODE_FADE) |-> ((fade_phase_ff == '0) && (fade_samples_ff == '0)), "fade counters moved outside crossfade")
   `KSCC_ASSERT_ALWAYS(a_phase_bounded, clock, reset, fade_phase_ff <= QUARTER_TURN, "fade phase passed a quarter turn")
   `KSCC_ASSERT_ALWAYS(a_flip_ends_fade, clock, reset, (live_select_ff != $past(live_select_ff)) |-> (($past(swap_mode_ff) == MODE_FADE) && (swap_mode_ff == MODE_STEADY)), "live engine flipped outside a crossfade end")
   `KSCC_ASSERT_NEXT(a_post_enters_warmup, clock, reset, step_en && post_accepted, swap_mode_ff == MODE_WARMUP, "accepted post did not enter warm-up")

endmodule

### design/kernel_swap_crossfade_controller_core.sv
// Crossfade controller for hot-swapping two stereo convolution engines. Each request word
// is either a stereo sample pair from both engines or a control event (post with known or
// unknown size, abandon); exactly one response word comes back per request, in order.
// The block takes one word per clock unless rsp_ready stalls it. A request register feeds
// the swap state machine and the two per-channel mixers (two 24x17 multiplies each), whose
// result lands in the response register. req_ready drops only when both registers are full
// and rsp_ready is low. Cosine and sine gains come from a registered quarter-sine ROM of
// 2^SINE_TABLE_BITS+1 entries, addressed with the next word's phase. Registers are to be
// written over the csr port only while idle, which is unchecked; csr_ready is always high.
module kernel_swap_crossfade_controller_core #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  kscc_pkg::req_type                   req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output kscc_pkg::rsp_type                   rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kscc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [kscc_pkg::PHASE_BITS-1:0]     csr_data
);
   import kscc_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             in_valid_ff, in_valid_in;
   req_type          in_word_ff;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_word_ff;
   rsp_type          out_word_in;
   logic             out_free;
   logic             step_en;
   logic             req_fire;
   mix_ctrl_type     mix_ctrl;
   swap_status_type  status;
   logic [PHASE_BITS-1:0] phase_next;
   logic [GAIN_BITS-1:0]  gain_new;
   logic [GAIN_BITS-1:0]  gain_old;
   logic signed [SAMPLE_BITS-1:0] mixed_left;
   logic signed [SAMPLE_BITS-1:0] mixed_right;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CROSSFADE_LENGTH:   cfg_in.crossfade_length   = csr_data[LEN_BITS-1:0];
            CSR_PHASE_STEP:         cfg_in.phase_step         = csr_data;
            CSR_WARMUP_BLOCK_LIMIT: cfg_in.warmup_block_limit = csr_data[BLOCK_BITS-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crossfade_length   <= FADE_LEN_RESET;
         cfg_ff.phase_step         <= PHASE_STEP_RESET;
         cfg_ff.warmup_block_limit <= WARMUP_LIM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline handshake: advance when the response register frees up
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step_en   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step_en) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load on their handshakes
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_word_ff <= req_word;
      end
      if (step_en) begin
         out_word_ff <= out_word_in;
      end
   end

   kscc_swap_ctrl u_swap_ctrl (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .word       (in_word_ff),
      .cfg        (cfg_ff),
      .mix_ctrl   (mix_ctrl),
      .status     (status),
      .phase_next (phase_next)
   );

   kscc_gain_rom #(
      .TABLE_BITS (SINE_TABLE_BITS)
   ) u_gain_rom (
      .clock    (clock),
      .phase    (phase_next),
      .gain_new (gain_new),
      .gain_old (gain_old)
   );

   kscc_blend u_blend_left (
      .ctrl     (mix_ctrl),
      .engine_a (in_word_ff.engine_a_left),
      .engine_b (in_word_ff.engine_b_left),
      .gain_new (gain_new),
      .gain_old (gain_old),
      .mixed    (mixed_left)
   );

   kscc_blend u_blend_right (
      .ctrl     (mix_ctrl),
      .engine_a (in_word_ff.engine_a_right),
      .engine_b (in_word_ff.engine_b_right),
      .gain_new (gain_new),
      .gain_old (gain_old),
      .mixed    (mixed_right)
   );

   // Assemble the response word
   always_comb begin
      out_word_in.out_left      = mixed_left;
      out_word_in.out_right     = mixed_right;
      out_word_in.live_engine   = status.live_engine;
      out_word_in.mode          = status.mode;
      out_word_in.post_accepted = status.post_accepted;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

### test/kernel_swap_crossfade_controller_core_test.sv
module kernel_swap_crossfade_controller_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import kscc_pkg::*;

   localparam int TABLE_BITS = 10;
   localparam int HOLD_CYCLES = 120;
   localparam int DRAIN_GUARD = 20000;
   localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef struct packed {
      logic [CSR_INDEX_BITS-1:0] idx;
      logic [PHASE_BITS-1:0]     data;
   } setting_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [PHASE_BITS-1:0] csr_data = '0;

   // Stimulus plumbing
   req_type pending_words[$];
   setting_write_type setting_writes[$];
   rsp_type predicted_outputs[$];
   int words_queued = 0;
   int words_accepted = 0;
   int writes_issued = 0;
   int settings_applied = 0;
   int sender_idle_pct = 34;
   int receiver_idle_pct = 75;
   int stall_orders = 0;
   int stall_served = 0;
   int stall_left = 0;
   int error_count = 0;
   int results_seen = 0;
   int unsigned cfg_len_now;

   // Shadow of the swap controller
   int unsigned fade_length_reg;
   int unsigned step_reg;
   int unsigned block_limit_reg;
   mode_type swap_state;
   bit live_b;
   int unsigned warm_blocks;
   int unsigned faded_count;
   int unsigned phase_acc;
   logic [SIZE_BITS-1:0] target_len;
   bit target_is_known;
   logic [SIZE_BITS-1:0] size_at_post;

   kernel_swap_crossfade_controller_core #(
      .SINE_TABLE_BITS(TABLE_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      if (error_count < 30) begin
         $display("mismatch on result %0d, %s: got %0d, want %0d", results_seen, what, got, want);
      end
      error_count++;
   endtask

   // Equal-power gain, Q1.15, from an odd polynomial in the table position
   function automatic int unsigned sine_gain(input int unsigned pos);
      longint unsigned coef[5];
      longint unsigned x;
      longint unsigned xx;
      longint unsigned acc;
      longint unsigned s;
      coef = '{SIN_C9, SIN_C7, SIN_C5, SIN_C3, SIN_C1};
      x = longint'(pos) << (16 - TABLE_BITS);
      xx = (x * x) >> 16;
      acc = coef[0];
      for (int i = 1; i < 5; i++) begin
         acc = coef[i] - ((acc * xx) >> 16);
      end
      s = (acc * x) >> 16;
      s = (s + 64'd16384) >> 15;
      if (s > UNITY_GAIN) begin
         s = UNITY_GAIN;
      end
      return int'(s);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] clip_sample(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         return S_MAX;
      end
      if (v < lo) begin
         return S_MIN;
      end
      return v[SAMPLE_BITS-1:0];
   endfunction

   // Weighted sum with round to nearest, floor on the halfway shift
   function automatic logic signed [SAMPLE_BITS-1:0] mix_channel(input longint live,
                                                                 input longint idle,
                                                                 input longint g_old,
                                                                 input longint g_new);
      longint acc;
      acc = live * g_old + idle * g_new + 16384;
      return clip_sample(acc >>> 15);
   endfunction

   task automatic drop_swap();
      swap_state = MODE_STEADY;
      warm_blocks = 0;
      faded_count = 0;
      phase_acc = 0;
      target_is_known = 1'b0;
   endtask

   task automatic reset_model();
      fade_length_reg = FADE_LEN_RESET;
      step_reg = PHASE_STEP_RESET;
      block_limit_reg = WARMUP_LIM_RESET;
      cfg_len_now = FADE_LEN_RESET;
      drop_swap();
      live_b = 1'b0;
      target_len = '0;
      size_at_post = '0;
   endtask

   task automatic apply_setting(input logic [CSR_INDEX_BITS-1:0] idx,
                                input logic [PHASE_BITS-1:0] data);
      case (idx)
         CSR_CROSSFADE_LENGTH:   fade_length_reg = data[LEN_BITS-1:0];
         CSR_PHASE_STEP:         step_reg = data;
         CSR_WARMUP_BLOCK_LIMIT: block_limit_reg = data[BLOCK_BITS-1:0];
         default: ;
      endcase
   endtask

   // Advance the shadow state by one accepted word and record its output
   task automatic advance_swap(input req_type w);
      rsp_type r;
      logic signed [SAMPLE_BITS-1:0] live_l, live_r, idle_l, idle_r;
      int unsigned pos;
      int unsigned g_new;
      int unsigned g_old;
      bit matched;
      r = '0;
      case (w.kind)
         KIND_POST_KNOWN, KIND_POST_UNKNOWN: begin
            if (swap_state == MODE_STEADY) begin
               target_len = (w.kind == KIND_POST_KNOWN) ? w.expected_size : '0;
               target_is_known = (w.kind == KIND_POST_KNOWN) && (w.expected_size != 0);
               size_at_post = w.size_before_load;
               swap_state = MODE_WARMUP;
               warm_blocks = 0;
               faded_count = 0;
               phase_acc = 0;
               r.post_accepted = 1'b1;
            end
         end
         KIND_ABANDON: drop_swap();
         KIND_SAMPLE: begin
            live_l = live_b ? w.engine_b_left : w.engine_a_left;
            live_r = live_b ? w.engine_b_right : w.engine_a_right;
            idle_l = live_b ? w.engine_a_left : w.engine_b_left;
            idle_r = live_b ? w.engine_a_right : w.engine_b_right;
            if (swap_state == MODE_FADE) begin
               pos = phase_acc >> (24 - TABLE_BITS);
               if (pos > (1 << TABLE_BITS)) begin
                  pos = 1 << TABLE_BITS;
               end
               g_new = sine_gain(pos);
               g_old = sine_gain((1 << TABLE_BITS) - pos);
               r.out_left = mix_channel(live_l, idle_l, g_old, g_new);
               r.out_right = mix_channel(live_r, idle_r, g_old, g_new);
               phase_acc = phase_acc + step_reg;
               if (phase_acc > QUARTER_TURN) begin
                  phase_acc = QUARTER_TURN;
               end
               if (faded_count < 65535) begin
                  faded_count++;
               end
               if (w.end_of_block && faded_count >= fade_length_reg) begin
                  live_b = !live_b;
                  drop_swap();
               end
            end else begin
               r.out_left = live_l;
               r.out_right = live_r;
               if (swap_state == MODE_WARMUP && w.end_of_block) begin
                  if (warm_blocks < 1023) begin
                     warm_blocks++;
                  end
                  if (target_is_known) begin
                     matched = (w.idle_reported_size == target_len);
                  end else begin
                     matched = (w.idle_reported_size != 0) &&
                               (w.idle_reported_size != size_at_post);
                  end
                  if (matched || warm_blocks >= block_limit_reg) begin
                     swap_state = MODE_FADE;
                     faded_count = 0;
                     phase_acc = 0;
                  end
               end
            end
         end
         default: ;
      endcase
      r.live_engine = live_b;
      r.mode = swap_state;
      predicted_outputs.push_back(r);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] any_sample();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 7))
         0: return S_MAX;
         1: return S_MIN;
         2: return SAMPLE_BITS'($signed($urandom_range(0, 15)) - 8);
         default: return r[SAMPLE_BITS-1:0];
      endcase
   endfunction

   function automatic logic [SIZE_BITS-1:0] any_size();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return SIZE_BITS'($urandom_range(1, 8));
         default: return r[SIZE_BITS-1:0];
      endcase
   endfunction

   function automatic req_type fresh_word(input kind_type k);
      req_type w;
      w = '0;
      w.kind = k;
      w.expected_size = any_size();
      w.size_before_load = any_size();
      w.engine_a_left = any_sample();
      w.engine_a_right = any_sample();
      w.engine_b_left = any_sample();
      w.engine_b_right = any_sample();
      w.end_of_block = ($urandom_range(0, 3) == 0);
      w.idle_reported_size = any_size();
      return w;
   endfunction

   function automatic req_type event_word(input kind_type k, input bit eob,
                                          input logic [SIZE_BITS-1:0] reported,
                                          input logic [SIZE_BITS-1:0] goal,
                                          input logic [SIZE_BITS-1:0] before_load);
      req_type w;
      w = fresh_word(k);
      w.end_of_block = eob;
      w.idle_reported_size = reported;
      w.expected_size = goal;
      w.size_before_load = before_load;
      return w;
   endfunction

   task automatic queue_word(input req_type w);
      pending_words.push_back(w);
      words_queued++;
   endtask

   // Post, warm up over a few blocks, then send fade samples; long fades are abandoned
   task automatic queue_swap_round();
      req_type w;
      logic [SIZE_BITS-1:0] goal;
      logic [SIZE_BITS-1:0] before_load;
      int blocks;
      int per_block;
      int fade_items;
      bit known;
      goal = any_size();
      before_load = any_size();
      known = ($urandom_range(0, 2) != 0);
      queue_word(event_word(known ? KIND_POST_KNOWN : KIND_POST_UNKNOWN, 1'b0, any_size(),
                            goal, before_load));
      blocks = $urandom_range(1, 4);
      for (int b = 0; b < blocks; b++) begin
         per_block = $urandom_range(1, 3);
         for (int s = 0; s < per_block; s++) begin
            w = fresh_word(KIND_SAMPLE);
            w.end_of_block = (s == per_block - 1);
            case ($urandom_range(0, 3))
               0: w.idle_reported_size = goal;
               1: w.idle_reported_size = before_load;
               2: w.idle_reported_size = '0;
               default: ;
            endcase
            queue_word(w);
         end
         if ($urandom_range(0, 7) == 0) begin
            queue_word(fresh_word(kind_type'($urandom_range(1, 3))));
         end
      end
      fade_items = $urandom_range(1, 20);
      for (int i = 0; i < fade_items; i++) begin
         w = fresh_word(KIND_SAMPLE);
         w.end_of_block = (i == fade_items - 1) || ($urandom_range(0, 3) == 0);
         queue_word(w);
      end
      // long fades never finish here: back out so the next post is taken
      if (cfg_len_now > 64 || $urandom_range(0, 9) == 0) begin
         queue_word(fresh_word(KIND_ABANDON));
      end
   endtask

   task automatic queue_random_phase(input int quota);
      int base;
      base = words_queued;
      while (words_queued - base < quota) begin
         if ($urandom_range(0, 4) != 0) begin
            queue_swap_round();
         end else begin
            queue_word(fresh_word(kind_type'($urandom_range(0, 3))));
         end
      end
   endtask

   // Wait until every queued word has been answered, then let the pipe empty
   task automatic settle();
      int guard;
      guard = 0;
      while ((words_accepted != words_queued || predicted_outputs.size() != 0) &&
             guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      if (predicted_outputs.size() != 0) begin
         flag_mismatch("results never delivered", predicted_outputs.size(), 0);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input int unsigned len, input int unsigned step,
                                 input int unsigned limit);
      setting_write_type sw;
      sw.idx = CSR_CROSSFADE_LENGTH;
      sw.data = PHASE_BITS'(len);
      setting_writes.push_back(sw);
      sw.idx = CSR_PHASE_STEP;
      sw.data = PHASE_BITS'(step);
      setting_writes.push_back(sw);
      sw.idx = CSR_WARMUP_BLOCK_LIMIT;
      sw.data = PHASE_BITS'(limit);
      setting_writes.push_back(sw);
      writes_issued += 3;
      cfg_len_now = len;
      while (settings_applied != writes_issued) begin
         @(posedge clock);
      end
   endtask

   // Request driver: hold the word until taken, then offer the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            advance_swap(req_word);
            words_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_word <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Register writer
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            apply_setting(csr_index, csr_data);
            settings_applied++;
         end
         if (!csr_valid || csr_ready) begin
            if (setting_writes.size() != 0) begin
               csr_index <= setting_writes[0].idx;
               csr_data <= setting_writes[0].data;
               void'(setting_writes.pop_front());
               csr_valid <= 1'b1;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and backpressure
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_outputs.size() == 0) begin
            flag_mismatch("result with nothing expected", rsp_word, 0);
         end else begin
            want = predicted_outputs.pop_front();
            if (rsp_word.out_left !== want.out_left)
               flag_mismatch("out_left", rsp_word.out_left, want.out_left);
            if (rsp_word.out_right !== want.out_right)
               flag_mismatch("out_right", rsp_word.out_right, want.out_right);
            if (rsp_word.live_engine !== want.live_engine)
               flag_mismatch("live_engine", rsp_word.live_engine, want.live_engine);
            if (rsp_word.mode !== want.mode)
               flag_mismatch("mode", rsp_word.mode, want.mode);
            if (rsp_word.post_accepted !== want.post_accepted)
               flag_mismatch("post_accepted", rsp_word.post_accepted, want.post_accepted);
         end
         results_seen++;
      end
      if (!reset && stall_served != stall_orders) begin
         stall_served++;
         stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   initial begin
      req_type w;
      int len;
      reset_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: pass-through, rejected posts, size checks, abandon
      w = event_word(KIND_SAMPLE, 1'b1, '0, '0, '0);
      w.engine_a_left = S_MAX;
      w.engine_a_right = S_MIN;
      w.engine_b_left = S_MIN;
      w.engine_b_right = S_MAX;
      queue_word(w);
      queue_word(event_word(KIND_ABANDON, 1'b1, '0, '0, '0));
      queue_word(event_word(KIND_POST_KNOWN, 1'b0, '0, 24'h000123, 24'h000100));
      queue_word(event_word(KIND_POST_UNKNOWN, 1'b0, '0, 24'h000456, 24'h000100));
      queue_word(event_word(KIND_SAMPLE, 1'b1, 24'h000999, '0, '0));
      queue_word(event_word(KIND_SAMPLE, 1'b0, 24'h000123, '0, '0));
      queue_word(event_word(KIND_SAMPLE, 1'b1, 24'h000123, '0, '0));
      w = event_word(KIND_SAMPLE, 1'b0, '0, '0, '0);
      w.engine_a_left = S_MAX;
      w.engine_b_left = S_MAX;
      w.engine_a_right = S_MIN;
      w.engine_b_right = S_MIN;
      queue_word(w);
      queue_word(event_word(KIND_SAMPLE, 1'b1, '0, '0, '0));
      queue_word(event_word(KIND_POST_KNOWN, 1'b0, '0, 24'h000123, 24'h000100));
      queue_word(event_word(KIND_ABANDON, 1'b0, '0, '0, '0));
      // known size of zero behaves as unknown
      queue_word(event_word(KIND_POST_KNOWN, 1'b0, '0, '0, 24'h000100));
      queue_word(event_word(KIND_SAMPLE, 1'b1, '0, '0, '0));
      queue_word(event_word(KIND_SAMPLE, 1'b1, 24'h000100, '0, '0));
      queue_word(event_word(KIND_SAMPLE, 1'b1, 24'h000200, '0, '0));
      queue_word(event_word(KIND_ABANDON, 1'b0, '0, '0, '0));
      settle();

      // Zero limit, zero length, zero step
      apply_settings(0, 0, 0);
      queue_word(event_word(KIND_POST_UNKNOWN, 1'b0, '0, '0, 24'h000055));
      queue_word(event_word(KIND_SAMPLE, 1'b1, 24'h000055, '0, '0));
      w = event_word(KIND_SAMPLE, 1'b0, '0, '0, '0);
      w.engine_a_left = S_MIN;
      w.engine_b_left = S_MAX;
      queue_word(w);
      queue_word(event_word(KIND_SAMPLE, 1'b0, '0, '0, '0));
      queue_word(event_word(KIND_SAMPLE, 1'b1, '0, '0, '0));
      w = event_word(KIND_SAMPLE, 1'b0, '0, '0, '0);
      w.engine_b_left = S_MAX;
      w.engine_b_right = S_MIN;
      queue_word(w);
      queue_word(event_word(KIND_POST_KNOWN, 1'b0, '0, 24'hFFFFFF, 24'hFFFFFF));
      queue_word(event_word(KIND_SAMPLE, 1'b1, 24'hFFFFFF, '0, '0));
      queue_word(event_word(KIND_SAMPLE, 1'b1, '0, '0, '0));
      settle();

      // Random traffic across a spread of settings
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: apply_settings(4, 1 << 22, 3);
            1: apply_settings(1, 1 << 24, 1);
            2: apply_settings(65535, 1, 1023);
            3: apply_settings(16, 1 << 20, 2);
            4: apply_settings(2, 1 << 23, 1023);
            default: begin
               len = $urandom_range(1, 12);
               apply_settings(len, (1 << 24) / len, $urandom_range(1, 6));
            end
         endcase
         if (p < 3) begin
            sender_idle_pct = 34;
            receiver_idle_pct = 75;
         end else if (p < 6) begin
            sender_idle_pct = 75;
            receiver_idle_pct = 34;
         end else begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         // long receiver hold-off while words keep coming
         if (p == 1) begin
            stall_orders++;
         end
         if (p == 4) begin
            queue_random_phase(20);
            settle();
            queue_random_phase(20);
         end else begin
            queue_random_phase(40);
         end
         settle();
      end

      repeat (5) @(posedge clock);
      if (error_count == 0) begin
         $display("kernel_swap_crossfade_controller_core_test OK");
      end else begin
         $display("kernel_swap_crossfade_controller_core_test NOT OK");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("kernel_swap_crossfade_controller_core_test NOT OK");
      $finish;
   end

endmodule
